/* rtl/acep_pkg.sv */
// shared types, byte codes and decode helpers for the arib code extension parser
package acep_pkg;

  // control bytes in the idle phase
  localparam logic [7:0] BYTE_ESC  = 8'h1b;
  localparam logic [7:0] BYTE_LS0  = 8'h0f;
  localparam logic [7:0] BYTE_LS1  = 8'h0e;
  localparam logic [7:0] BYTE_SS2  = 8'h19;
  localparam logic [7:0] BYTE_SS3  = 8'h1d;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // bytes that follow esc, and the drcs final range
  localparam logic [7:0] ESC_DBL   = 8'h24;
  localparam logic [7:0] ESC_G0    = 8'h28;
  localparam logic [7:0] ESC_G3    = 8'h2b;
  localparam logic [7:0] ESC_LS2   = 8'h6e;
  localparam logic [7:0] ESC_LS3   = 8'h6f;
  localparam logic [7:0] ESC_LS1R  = 8'h7e;
  localparam logic [7:0] ESC_LS2R  = 8'h7d;
  localparam logic [7:0] ESC_LS3R  = 8'h7c;
  localparam logic [7:0] DRCS_LO   = 8'h40;
  localparam logic [7:0] DRCS_HI   = 8'h4f;

  // final bytes of designations
  localparam logic [7:0] FIN_KANJI = 8'h42;
  localparam logic [7:0] FIN_ALNUM = 8'h4a;
  localparam logic [7:0] FIN_SET_LO = 8'h30;
  localparam logic [7:0] FIN_SET_HI = 8'h38;
  localparam logic [7:0] FIN_X0201 = 8'h49;
  localparam logic [7:0] FIN_JIS1  = 8'h39;
  localparam logic [7:0] FIN_JIS2  = 8'h3a;
  localparam logic [7:0] FIN_SYMB  = 8'h3b;

  // planes
  localparam logic [4:0] PL_KANJI  = 5'd0;
  localparam logic [4:0] PL_ALNUM  = 5'd1;
  localparam logic [4:0] PL_HIRA   = 5'd2;
  localparam logic [4:0] PL_KATA   = 5'd3;
  localparam logic [4:0] PL_X0201  = 5'd11;
  localparam logic [4:0] PL_JIS1   = 5'd12;
  localparam logic [4:0] PL_JIS2   = 5'd13;
  localparam logic [4:0] PL_SYMB   = 5'd14;
  localparam logic [4:0] PL_DRCS0  = 5'd15;
  localparam logic [4:0] PL_NONE   = 5'd31;

  // invocation slots
  localparam logic [1:0] SLOT_G0 = 2'd0;
  localparam logic [1:0] SLOT_G1 = 2'd1;
  localparam logic [1:0] SLOT_G2 = 2'd2;
  localparam logic [1:0] SLOT_G3 = 2'd3;

  // character kinds
  localparam logic [1:0] KIND_SINGLE  = 2'd0;
  localparam logic [1:0] KIND_DOUBLE  = 2'd1;
  localparam logic [1:0] KIND_SPACE   = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_END     = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [1:0] ERR_SIZE    = 2'd3;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_ESC   = 7'b0000010,
    PH_ESC24 = 7'b0000100,
    PH_SLOT  = 7'b0001000,
    PH_DRCS  = 7'b0010000,
    PH_GL2   = 7'b0100000,
    PH_GR2   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [3:0][4:0] dset;
    logic [1:0]      gl;
    logic [1:0]      gr;
    logic            ss_pend;
    logic [1:0]      ss_ret;
    phase_t          phase;
    logic [1:0]      slot;
    logic            dbl;
    logic [7:0]      held;
    logic            skip;
  } st_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [4:0] plane;
    logic [6:0] c1;
    logic [6:0] c2;
    logic [1:0] err;
  } res_t;

  localparam st_t ST_RESET = '{
    dset:    {PL_KATA, PL_HIRA, PL_ALNUM, PL_KANJI},
    gl:      SLOT_G0,
    gr:      SLOT_G2,
    ss_pend: 1'b0,
    ss_ret:  SLOT_G0,
    phase:   PH_IDLE,
    slot:    SLOT_G0,
    dbl:     1'b0,
    held:    8'h00,
    skip:    1'b0
  };

  function automatic logic plane_is_double(input logic [4:0] p);
    return (p == PL_KANJI) || (p == PL_JIS1) || (p == PL_JIS2) ||
           (p == PL_SYMB) || (p == PL_DRCS0);
  endfunction

  function automatic logic [4:0] plane_of_final(input logic [7:0] f);
    logic [4:0] p;
    p = PL_NONE;
    if (f == FIN_KANJI) p = PL_KANJI;
    else if (f == FIN_ALNUM) p = PL_ALNUM;
    else if (f >= FIN_SET_LO && f <= FIN_SET_HI) p = 5'(f[3:0]) + PL_HIRA;
    else if (f == FIN_X0201) p = PL_X0201;
    else if (f == FIN_JIS1) p = PL_JIS1;
    else if (f == FIN_JIS2) p = PL_JIS2;
    else if (f == FIN_SYMB) p = PL_SYMB;
    return p;
  endfunction

endpackage

/* rtl/acep_step.sv */
// per-byte decode: next parser state and the result of one byte
module acep_step
  import acep_pkg::*;
(
  input  st_t        st_i,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output st_t        st_o,
  output logic       emit_o,
  output res_t       res_o
);

  st_t        nxt;
  res_t       res;
  logic [1:0] err;
  logic       gl_done;
  logic       is_gl;
  logic       is_gr;
  logic [4:0] sel_p;
  logic [6:0] c7;
  logic [6:0] top;
  logic       des_req;
  logic [1:0] des_slot;
  logic [4:0] des_p;
  logic       des_dbl;

  assign is_gl = (data_byte >= BYTE_SPACE) && (data_byte < 8'h7f);
  assign is_gr = data_byte[7] && (data_byte[6:0] >= 7'h20);
  assign sel_p = st_i.dset[is_gl ? st_i.gl : st_i.gr];
  assign c7    = data_byte[6:0];
  assign top   = (sel_p == PL_X0201) ? 7'h7f : 7'h7e;

  always_comb begin
    nxt      = st_i;
    res      = '0;
    err      = ERR_NONE;
    gl_done  = 1'b0;
    des_req  = 1'b0;
    des_slot = SLOT_G0;
    des_p    = PL_NONE;
    des_dbl  = 1'b0;

    if (!st_i.skip) begin
      unique case (st_i.phase)
        PH_ESC: begin
          nxt.phase = PH_IDLE;
          if (data_byte >= ESC_G0 && data_byte <= ESC_G3) begin
            nxt.slot  = data_byte[1:0];
            nxt.dbl   = 1'b0;
            nxt.phase = PH_SLOT;
          end else if (data_byte == ESC_DBL) begin
            nxt.phase = PH_ESC24;
          end else if (data_byte == ESC_LS2) begin
            nxt.gl = SLOT_G2;
          end else if (data_byte == ESC_LS3) begin
            nxt.gl = SLOT_G3;
          end else if (data_byte == ESC_LS1R) begin
            nxt.gr = SLOT_G1;
          end else if (data_byte == ESC_LS2R) begin
            nxt.gr = SLOT_G2;
          end else if (data_byte == ESC_LS3R) begin
            nxt.gr = SLOT_G3;
          end
        end
        PH_ESC24: begin
          nxt.phase = PH_IDLE;
          if (data_byte >= ESC_G0 && data_byte <= ESC_G3) begin
            nxt.slot  = data_byte[1:0];
            nxt.dbl   = 1'b1;
            nxt.phase = PH_SLOT;
          end else begin
            // two-byte form without intermediate goes to g0
            des_req  = 1'b1;
            des_slot = SLOT_G0;
            des_p    = plane_of_final(data_byte);
            des_dbl  = 1'b1;
          end
        end
        PH_SLOT: begin
          nxt.phase = PH_IDLE;
          if (data_byte == BYTE_SPACE) begin
            nxt.phase = PH_DRCS;
          end else begin
            des_req  = 1'b1;
            des_slot = st_i.slot;
            des_p    = plane_of_final(data_byte);
            des_dbl  = st_i.dbl;
          end
        end
        PH_DRCS: begin
          nxt.phase = PH_IDLE;
          if (data_byte >= DRCS_LO && data_byte <= DRCS_HI) begin
            des_req  = 1'b1;
            des_slot = st_i.slot;
            des_p    = 5'(data_byte[3:0]) + PL_DRCS0;
            des_dbl  = st_i.dbl;
          end else begin
            err = ERR_UNKNOWN;
          end
        end
        PH_GL2, PH_GR2: begin
          res.valid = 1'b1;
          res.kind  = KIND_DOUBLE;
          res.plane = st_i.dset[(st_i.phase == PH_GL2) ? st_i.gl : st_i.gr];
          res.c1    = st_i.held[6:0];
          res.c2    = c7;
          gl_done   = (st_i.phase == PH_GL2);
          nxt.phase = PH_IDLE;
        end
        PH_IDLE: begin
          nxt.phase = PH_IDLE;
          if (is_gl || is_gr) begin
            if (plane_is_double(sel_p) && (data_byte != BYTE_SPACE)) begin
              nxt.held  = data_byte;
              nxt.phase = is_gl ? PH_GL2 : PH_GR2;
            end else begin
              res.valid = 1'b1;
              res.plane = sel_p;
              res.c1    = c7;
              if (c7 == BYTE_SPACE[6:0]) res.kind = KIND_SPACE;
              else if (c7 < 7'h20 || c7 > top) res.kind = KIND_INVALID;
              else res.kind = KIND_SINGLE;
              gl_done = is_gl;
            end
          end else if (data_byte == BYTE_ESC) begin
            nxt.phase = PH_ESC;
          end else if (data_byte == BYTE_LS0) begin
            nxt.gl = SLOT_G0;
          end else if (data_byte == BYTE_LS1) begin
            nxt.gl = SLOT_G1;
          end else if (data_byte == BYTE_SS2 || data_byte == BYTE_SS3) begin
            if (!st_i.ss_pend) begin
              nxt.ss_ret  = st_i.gl;
              nxt.ss_pend = 1'b1;
            end
            nxt.gl = (data_byte == BYTE_SS2) ? SLOT_G2 : SLOT_G3;
          end
        end
        default: nxt.phase = PH_IDLE;
      endcase

      if (des_req) begin
        if (des_p == PL_NONE) err = ERR_UNKNOWN;
        else if (plane_is_double(des_p) != des_dbl) err = ERR_SIZE;
        else nxt.dset[des_slot] = des_p;
      end

      // single shift returns after one gl character
      if (gl_done && st_i.ss_pend) begin
        nxt.gl      = st_i.ss_ret;
        nxt.ss_pend = 1'b0;
      end

      if (err != ERR_NONE) begin
        nxt.skip  = 1'b1;
        nxt.phase = PH_IDLE;
      end else if (last_byte && nxt.phase != PH_IDLE) begin
        err = ERR_END;
      end
    end

    res.err = err;
    if (last_byte) nxt = ST_RESET;
  end

  assign st_o   = nxt;
  assign res_o  = res;
  assign emit_o = last_byte | (~st_i.skip & (res.valid | (err != ERR_NONE)));

endmodule

/* rtl/arib_code_extension_parser.sv */
// top level: byte stream in, character and error beats out
// Decodes an ARIB 8-unit coded string one byte per beat. Each input beat is a
// byte (tlast marks the end of the string); it sits in an input register
// while the decode logic updates the G0-G3 designations, the GL/GR
// invocations and the single-shift return, then at most one result beat is
// loaded into the output register. A result appears for every character, for
// every error and for the last byte (which carries tlast). The block takes a
// byte every cycle unless stalled, and a byte that gives no result just
// updates state. The output register stalls the decode stage when a result
// waits and out_tready is low; the input side then holds one byte in its
// register. All state returns to reset after the last byte, and after an
// error bytes give no result until that last byte.
module arib_code_extension_parser
  import acep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] char_valid, [2:1] char_kind, [7:3] plane,
                                  // [14:8] first_code, [21:15] second_code,
                                  // [23:22] error_code
  output logic        out_tlast   // string_end
);

  // input register
  logic       s1_v_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  // parser state
  st_t  st_r;
  st_t  st_nxt;

  // result register
  logic out_v_r;
  res_t out_res_r;
  logic out_last_r;

  logic out_free;
  logic fire;
  logic emit;
  res_t res;

  // decode stage runs when a byte waits and the output register can take a beat
  assign out_free  = ~out_v_r | out_tready;
  assign fire      = s1_v_r & out_free;
  assign in_tready = ~s1_v_r | fire;

  acep_step u_step (
    .st_i      (st_r),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .st_o      (st_nxt),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= fire & emit;
    end
  end

  // result payload, loaded only with a new beat
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res_r  <= res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_res_r.err, out_res_r.c2, out_res_r.c1,
                       out_res_r.plane, out_res_r.kind, out_res_r.valid};

`ifndef SYNTHESIS
  // a string end puts every piece of state back to reset
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r) |=> (st_r == ST_RESET))
    else $error("state not reset after last byte");

  // a character beat never carries an error
  a_char_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.valid) |-> (out_res_r.err == ERR_NONE))
    else $error("character beat with error code");

  // an empty character slot has zero character fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_res_r.valid) |->
      (out_res_r.kind == 2'd0 && out_res_r.plane == 5'd0 &&
       out_res_r.c1 == 7'd0 && out_res_r.c2 == 7'd0))
    else $error("nonzero character fields without a character");

  // while skipping after an error only the last byte produces a beat
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && st_r.skip && !s1_last_r) |=> !out_v_r)
    else $error("beat produced while skipping");
`endif

endmodule

/* bench/char_stream_checker.sv */
// checker for the arib decoder: predicts result beats from accepted bytes and compares them
`timescale 1ns / 1ps
module char_stream_checker
  import acep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding,
  output int          beats_seen,
  output int          error_beats
);

  typedef struct packed {
    res_t res;
    logic fin;
  } decoded_t;

  decoded_t expected_chars[$];

  // decoder state, kept apart from the block
  logic [4:0] gset [4];
  logic [1:0] gl_inv;
  logic [1:0] gr_inv;
  logic       ss_pend;
  logic [1:0] ss_ret;
  phase_t     ph;
  logic [1:0] tslot;
  logic       tdbl;
  logic [7:0] held;
  logic       skip;

  int n_bad = 0;
  int n_beats = 0;
  int n_err = 0;

  function automatic logic is_two_byte(input logic [4:0] p);
    return p == PL_KANJI || p == PL_JIS1 || p == PL_JIS2 || p == PL_SYMB || p == PL_DRCS0;
  endfunction

  function automatic logic [4:0] final_to_plane(input logic [7:0] f);
    if (f == FIN_KANJI) return PL_KANJI;
    if (f == FIN_ALNUM) return PL_ALNUM;
    if (f >= FIN_SET_LO && f <= FIN_SET_HI) return PL_HIRA + 5'(f - FIN_SET_LO);
    if (f == FIN_X0201) return PL_X0201;
    if (f == FIN_JIS1) return PL_JIS1;
    if (f == FIN_JIS2) return PL_JIS2;
    if (f == FIN_SYMB) return PL_SYMB;
    return PL_NONE;
  endfunction

  // unknown set and size mismatch leave the slot as it was
  function automatic logic [1:0] designate(input logic [1:0] slot, input logic [4:0] p,
                                           input logic want_dbl);
    if (p == PL_NONE) return ERR_UNKNOWN;
    if (is_two_byte(p) != want_dbl) return ERR_SIZE;
    gset[slot] = p;
    return ERR_NONE;
  endfunction

  task automatic reset_decoder();
    gset[0] = PL_KANJI;
    gset[1] = PL_ALNUM;
    gset[2] = PL_HIRA;
    gset[3] = PL_KATA;
    gl_inv = SLOT_G0;
    gr_inv = SLOT_G2;
    ss_pend = 1'b0;
    ss_ret = SLOT_G0;
    ph = PH_IDLE;
    tslot = SLOT_G0;
    tdbl = 1'b0;
    held = 8'h00;
    skip = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    decoded_t d;
    logic emit;
    logic gl_done;
    logic gl;
    logic gr;
    logic [4:0] p;
    logic [6:0] c;
    d = '0;
    emit = 1'b0;
    gl_done = 1'b0;
    if (!skip) begin
      case (ph)
        PH_ESC: begin
          if (b >= ESC_G0 && b <= ESC_G3) begin
            tslot = 2'(b - ESC_G0);
            tdbl = 1'b0;
            ph = PH_SLOT;
          end else if (b == ESC_DBL) begin
            ph = PH_ESC24;
          end else begin
            case (b)
              ESC_LS2:  gl_inv = SLOT_G2;
              ESC_LS3:  gl_inv = SLOT_G3;
              ESC_LS1R: gr_inv = SLOT_G1;
              ESC_LS2R: gr_inv = SLOT_G2;
              ESC_LS3R: gr_inv = SLOT_G3;
              default: ;
            endcase
            ph = PH_IDLE;
          end
        end
        PH_ESC24: begin
          if (b >= ESC_G0 && b <= ESC_G3) begin
            tslot = 2'(b - ESC_G0);
            tdbl = 1'b1;
            ph = PH_SLOT;
          end else begin
            // short two-byte form always targets g0
            d.res.err = designate(SLOT_G0, final_to_plane(b), 1'b1);
            ph = PH_IDLE;
          end
        end
        PH_SLOT: begin
          if (b == BYTE_SPACE) begin
            ph = PH_DRCS;
          end else begin
            d.res.err = designate(tslot, final_to_plane(b), tdbl);
            ph = PH_IDLE;
          end
        end
        PH_DRCS: begin
          if (b >= DRCS_LO && b <= DRCS_HI)
            d.res.err = designate(tslot, PL_DRCS0 + {1'b0, b[3:0]}, tdbl);
          else
            d.res.err = ERR_UNKNOWN;
          ph = PH_IDLE;
        end
        PH_GL2, PH_GR2: begin
          d.res.valid = 1'b1;
          d.res.kind = KIND_DOUBLE;
          d.res.plane = gset[ph == PH_GL2 ? gl_inv : gr_inv];
          d.res.c1 = held[6:0];
          d.res.c2 = b[6:0];
          gl_done = (ph == PH_GL2);
          ph = PH_IDLE;
        end
        default: begin
          gl = (b >= 8'h20 && b < 8'h7f);
          gr = (b >= 8'ha0);
          ph = PH_IDLE;
          if (gl || gr) begin
            p = gset[gl ? gl_inv : gr_inv];
            if (is_two_byte(p) && b != BYTE_SPACE) begin
              held = b;
              ph = gl ? PH_GL2 : PH_GR2;
            end else begin
              c = b[6:0];
              d.res.valid = 1'b1;
              d.res.plane = p;
              d.res.c1 = c;
              if (c == 7'h20)
                d.res.kind = KIND_SPACE;
              else if (c < 7'h20 || c > (p == PL_X0201 ? 7'h7f : 7'h7e))
                d.res.kind = KIND_INVALID;
              else
                d.res.kind = KIND_SINGLE;
              gl_done = gl;
            end
          end else begin
            case (b)
              BYTE_ESC: ph = PH_ESC;
              BYTE_LS0: gl_inv = SLOT_G0;
              BYTE_LS1: gl_inv = SLOT_G1;
              BYTE_SS2, BYTE_SS3: begin
                if (!ss_pend) begin
                  ss_ret = gl_inv;
                  ss_pend = 1'b1;
                end
                gl_inv = (b == BYTE_SS2) ? SLOT_G2 : SLOT_G3;
              end
              default: ;
            endcase
          end
        end
      endcase

      // single shift is used up by one gl character
      if (gl_done && ss_pend) begin
        gl_inv = ss_ret;
        ss_pend = 1'b0;
      end
      if (d.res.valid) emit = 1'b1;
      if (d.res.err != ERR_NONE) begin
        emit = 1'b1;
        skip = 1'b1;
        ph = PH_IDLE;
      end else if (fin && ph != PH_IDLE) begin
        d.res.err = ERR_END;
      end
    end
    if (fin) emit = 1'b1;
    if (emit) begin
      d.fin = fin;
      expected_chars.push_back(d);
    end
    if (fin) reset_decoder();
  endtask

  function automatic logic check_field(input string name, input logic [6:0] want,
                                       input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic compare_beat();
    decoded_t d;
    logic bad;
    if (expected_chars.size() == 0) begin
      $error("result beat with no character expected: tdata 0x%0h", out_tdata);
      n_bad++;
    end else begin
      d = expected_chars.pop_front();
      bad = 1'b0;
      bad |= check_field("char_valid", 7'(d.res.valid), 7'(out_tdata[0]));
      bad |= check_field("char_kind", 7'(d.res.kind), 7'(out_tdata[2:1]));
      bad |= check_field("plane", 7'(d.res.plane), 7'(out_tdata[7:3]));
      bad |= check_field("first_code", d.res.c1, out_tdata[14:8]);
      bad |= check_field("second_code", d.res.c2, out_tdata[21:15]);
      bad |= check_field("string_end", 7'(d.fin), 7'(out_tlast));
      bad |= check_field("error_code", 7'(d.res.err), 7'(out_tdata[23:22]));
      if (bad) n_bad++;
      n_beats++;
      if (d.res.err != ERR_NONE) n_err++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_decoder();
      expected_chars.delete();
    end else begin
      // a result beat never comes from the byte taken at the same edge
      if (out_tvalid && out_tready) compare_beat();
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    mismatches <= n_bad;
    outstanding <= expected_chars.size();
    beats_seen <= n_beats;
    error_beats <= n_err;
  end

endmodule

/* bench/testbench.sv */
// top of the arib decoder bench: clock, reset, byte strings, receiver pacing and verdict
`timescale 1ns / 1ps
module testbench;
  import acep_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int PHASE_ITEMS = 265;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int beats_seen;
  int error_beats;

  // pacing knobs, percent per cycle
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet = 0;

  int sent = 0;
  int strings = 0;
  logic [7:0] str_bytes[$];

  always #10 clk = ~clk;

  arib_code_extension_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  char_stream_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .beats_seen  (beats_seen),
    .error_beats (error_beats)
  );

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: any stretch without a beat on either side is a hang
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one byte beat, with random sender gaps in front of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // sender goes quiet until every expected result beat has arrived
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] single_final();
    int r;
    r = $urandom_range(0, 10);
    if (r == 0) return FIN_ALNUM;
    if (r == 10) return FIN_X0201;
    return FIN_SET_LO + 8'(r - 1);
  endfunction

  function automatic logic [7:0] double_final();
    case ($urandom_range(0, 3))
      0: return FIN_KANJI;
      1: return FIN_JIS1;
      2: return FIN_JIS2;
      default: return FIN_SYMB;
    endcase
  endfunction

  // escape designation, mostly well formed; a few have a bad final or the wrong size
  task automatic add_designation();
    logic [7:0] g;
    logic bad;
    g = ESC_G0 + 8'($urandom_range(0, 3));
    bad = ($urandom_range(24) == 0);
    str_bytes.push_back(BYTE_ESC);
    case ($urandom_range(0, 3))
      0: begin
        str_bytes.push_back(g);
        str_bytes.push_back(bad ? 8'($urandom_range(0, 255)) : single_final());
      end
      1: begin
        str_bytes.push_back(ESC_DBL);
        // short form for g0 half the time
        if (g != ESC_G0 || $urandom_range(1)) str_bytes.push_back(g);
        str_bytes.push_back(bad ? single_final() : double_final());
      end
      2: begin
        str_bytes.push_back(g);
        str_bytes.push_back(BYTE_SPACE);
        str_bytes.push_back(bad ? DRCS_LO : DRCS_LO + 8'($urandom_range(1, 15)));
      end
      default: begin
        str_bytes.push_back(ESC_DBL);
        str_bytes.push_back(g);
        str_bytes.push_back(BYTE_SPACE);
        str_bytes.push_back(bad ? 8'($urandom_range(0, 255)) : DRCS_LO);
      end
    endcase
  endtask

  task automatic add_chunk();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      str_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end else if (r < 60) begin
      str_bytes.push_back(8'($urandom_range(8'ha0, 8'hff)));
    end else if (r < 72) begin
      case ($urandom_range(0, 8))
        0: str_bytes.push_back(BYTE_LS0);
        1: str_bytes.push_back(BYTE_LS1);
        2: str_bytes.push_back(BYTE_SS2);
        3: str_bytes.push_back(BYTE_SS3);
        4: begin str_bytes.push_back(BYTE_ESC); str_bytes.push_back(ESC_LS2); end
        5: begin str_bytes.push_back(BYTE_ESC); str_bytes.push_back(ESC_LS3); end
        6: begin str_bytes.push_back(BYTE_ESC); str_bytes.push_back(ESC_LS1R); end
        7: begin str_bytes.push_back(BYTE_ESC); str_bytes.push_back(ESC_LS2R); end
        default: begin str_bytes.push_back(BYTE_ESC); str_bytes.push_back(ESC_LS3R); end
      endcase
    end else if (r < 90) begin
      add_designation();
    end else begin
      // noise: any byte, controls included
      str_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // builds a string of chunks; one in eight is cut short, often mid-sequence
  task automatic send_random_string();
    int len;
    len = $urandom_range(1, 40);
    str_bytes.delete();
    while (str_bytes.size() < len) add_chunk();
    if ($urandom_range(7) == 0)
      while (str_bytes.size() > len) void'(str_bytes.pop_back());
    for (int i = 0; i < str_bytes.size(); i++)
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    strings++;
  endtask

  initial begin
    int target;
    logic drained;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // kanji pair with the top second byte, then a gl space ends the string
    send_byte(8'h41, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(BYTE_SPACE, 1'b1);
    // x0201 katakana into g2: gr 0xff is a character there, gr 0xa0 a space;
    // then alnum via ls1, and a zero byte as the last one
    send_byte(BYTE_ESC, 1'b0);
    send_byte(ESC_G0 + 8'd2, 1'b0);
    send_byte(FIN_X0201, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha0, 1'b0);
    send_byte(BYTE_LS1, 1'b0);
    send_byte(8'h7e, 1'b0);
    send_byte(8'h00, 1'b1);
    // double-byte drcs into g3, single shift to it, pair, then the string
    // ends on the first half of a kanji pair
    send_byte(BYTE_ESC, 1'b0);
    send_byte(ESC_DBL, 1'b0);
    send_byte(ESC_G3, 1'b0);
    send_byte(BYTE_SPACE, 1'b0);
    send_byte(DRCS_LO, 1'b0);
    send_byte(BYTE_SS3, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h21, 1'b1);
    // single-byte set through the two-byte form, rest of string skipped
    send_byte(BYTE_ESC, 1'b0);
    send_byte(ESC_DBL, 1'b0);
    send_byte(FIN_ALNUM, 1'b0);
    send_byte(8'h41, 1'b1);
    // drcs final outside its range on the last byte
    send_byte(BYTE_ESC, 1'b0);
    send_byte(ESC_G0 + 8'd1, 1'b0);
    send_byte(BYTE_SPACE, 1'b0);
    send_byte(8'h3f, 1'b1);
    drain_wait();

    // four pacing phases: none, sender gaps, receiver stalls, both light
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 51 : (p == 3) ? 11 : 0;
      stall_pct <= (p == 2) ? 51 : (p == 3) ? 11 : 0;
      if (p == 2) hold_asks <= hold_asks + 1;  // fill the block while it is held off
      target = sent + PHASE_ITEMS;
      drained = 1'b0;
      while (sent < target) begin
        send_random_string();
        if (!drained && sent >= target - PHASE_ITEMS / 2) begin
          drain_wait();
          drained = 1'b1;
        end
      end
    end

    drain_wait();
    repeat (8) @(posedge clk);
    $display("covered %0d strings, %0d bytes over four pacing phases and a long hold-off",
             strings, sent);
    $display("%0d result beats compared, %0d of them with an error code", beats_seen,
             error_beats);
    if (mismatches == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/acep_pkg.sv
rtl/acep_step.sv
rtl/arib_code_extension_parser.sv
bench/char_stream_checker.sv
bench/testbench.sv
